FILE: design/prcc_pkg.sv
// ============================================================================
// prcc_pkg
// Shared types and constants for the packet rate congestion controller.
// ============================================================================
package prcc_pkg;

    // Fixed point and sequence number sizes.
    localparam int FRACTION_BITS = 16;
    localparam int SEQUENCE_BITS = 32;

    // Field widths.
    localparam int RATE_W    = 32;
    localparam int QUEUED_W  = 32;
    localparam int DESIRED_W = 16;
    localparam int PSIZE_W   = 16;
    localparam int WHOLE_W   = 16;

    // Desired count after adding the quotient can carry one bit.
    localparam int SUM_W = QUEUED_W + 1;

    // Divider step count and its counter width.
    localparam int DIV_STEPS = QUEUED_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Reset values.
    localparam logic [PSIZE_W-1:0] PACKET_SIZE_RESET = PSIZE_W'(3000);
    localparam logic [RATE_W-1:0]  ONE_FIXED = RATE_W'(64'd1 << FRACTION_BITS);
    localparam logic [63:0] THRESHOLD_WIDE = 64'd1000 << FRACTION_BITS;
    localparam logic [RATE_W-1:0] THRESHOLD_RESET =
        (THRESHOLD_WIDE > 64'hFFFF_FFFF) ? {RATE_W{1'b1}} : THRESHOLD_WIDE[RATE_W-1:0];

    // Event kinds.
    localparam logic [1:0] MODE_GROUP = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_LOSS  = 2'd2;
    localparam logic [1:0] MODE_SENT  = 2'd3;

    // Input request payload.
    typedef struct packed {
        logic [1:0]           mode;
        logic [DESIRED_W-1:0] desired_packets;
        logic [QUEUED_W-1:0]  bytes_queued;
        logic [31:0]          packet_number;
    } t_in_item;

    // Result payload.
    typedef struct packed {
        logic [WHOLE_W-1:0] whole_packets;
        logic [RATE_W-1:0]  packets_per_group;
        logic [RATE_W-1:0]  slow_start_limit;
    } t_out_item;

    // Controller sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_CALC = 3'b100
    } t_state;

endpackage

FILE: design/packet_rate_congestion_control.sv
// ============================================================================
// packet_rate_congestion_control
// Sender packet rate controller with slow start and rate halving on loss.
// ============================================================================
// Usage:
// Events enter on the input channel (i_in_valid / o_in_ready / i_in_data) and
// each one yields exactly one result on the output channel (o_out_valid /
// i_out_ready / o_out_data). One event is in work at a time.
// A group event converts the queued bytes to packets with a bit-serial
// restoring divider that retires one quotient bit per cycle; the ST_DIV steps
// are followed by the ST_CALC update, which registers the result.
// Acknowledge, loss and sent events skip the divider and go straight to
// ST_CALC, which registers the result once the output register is free.
// The input is ready again once the result is registered, so a new event is
// taken only after the last one has finished.
// The packet size register is written on the cfg channel (always ready) and
// should only change while no event is in work.
// Reset (i_rst_n low, synchronous) restores rate 1.0, threshold 1000.0, zero
// credit, guards and sent count, and packet size 3000.
// When the receiver stalls, the result waits in the output register while a
// new request may be accepted; that request completes only once the output
// register is free again.
// ============================================================================
module packet_rate_congestion_control
    import prcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [PSIZE_W-1:0] i_cfg_data
);

    // Control and state registers.
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    logic [PSIZE_W-1:0]       r_psize;
    logic [RATE_W-1:0]        r_rate, n_rate;
    logic [RATE_W-1:0]        r_credit, n_credit;
    logic [RATE_W-1:0]        r_thresh, n_thresh;
    logic [SEQUENCE_BITS-1:0] r_inc_guard, n_inc_guard;
    logic [SEQUENCE_BITS-1:0] r_dec_guard, n_dec_guard;
    logic [SEQUENCE_BITS-1:0] r_sent, n_sent;

    // Captured request and divider datapath.
    logic [1:0]               r_mode, n_mode;
    logic [DESIRED_W-1:0]     r_desired, n_desired;
    logic [SEQUENCE_BITS-1:0] r_pnum, n_pnum;
    logic [QUEUED_W-1:0]      r_quot, n_quot;
    logic [PSIZE_W-1:0]       r_rem, n_rem;
    logic [PSIZE_W-1:0]       r_div, n_div;
    t_out_item                r_out, n_out;

    // Combinational helpers.
    logic                     in_fire;
    logic                     out_free;
    logic [PSIZE_W:0]         rem_shift;
    logic                     rem_ge;
    logic [SUM_W-1:0]         desired_sum;
    logic [RATE_W:0]          credit_sum;
    logic [SUM_W-1:0]         whole_raw;
    logic [SUM_W-1:0]         whole_cap;
    logic [WHOLE_W-1:0]       whole_sat;
    logic [SUM_W-1:0]         rate_whole;
    logic [RATE_W:0]          rate_inc;
    logic [RATE_W-1:0]        rate_half;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {r_rem, r_quot[QUEUED_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_div});

    // Group arithmetic on the finished quotient.
    assign desired_sum = SUM_W'(r_desired) + SUM_W'(r_quot);
    assign credit_sum  = {1'b0, r_credit} + {1'b0, r_rate};
    assign whole_raw   = SUM_W'(credit_sum >> FRACTION_BITS);
    assign whole_cap   = (whole_raw > desired_sum) ? desired_sum : whole_raw;
    assign whole_sat   = (whole_cap > SUM_W'({WHOLE_W{1'b1}})) ? {WHOLE_W{1'b1}}
                                                               : whole_cap[WHOLE_W-1:0];
    // desired << FRACTION_BITS <= rate holds exactly when desired <= whole part of rate.
    assign rate_whole  = SUM_W'(r_rate >> FRACTION_BITS);

    // Acknowledge and loss rate updates.
    assign rate_inc  = {1'b0, r_rate} + {1'b0, ONE_FIXED};
    assign rate_half = ((r_rate >> 1) < ONE_FIXED) ? ONE_FIXED : (r_rate >> 1);

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_rate      = r_rate;
        n_credit    = r_credit;
        n_thresh    = r_thresh;
        n_inc_guard = r_inc_guard;
        n_dec_guard = r_dec_guard;
        n_sent      = r_sent;
        n_mode      = r_mode;
        n_desired   = r_desired;
        n_pnum      = r_pnum;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_div       = r_div;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_mode    = i_in_data.mode;
                    n_desired = i_in_data.desired_packets;
                    n_pnum    = i_in_data.packet_number[SEQUENCE_BITS-1:0];
                    n_quot    = i_in_data.bytes_queued;
                    n_rem     = '0;
                    n_div     = (r_psize == '0) ? PSIZE_W'(1) : r_psize;
                    n_cnt     = '0;
                    n_state   = (i_in_data.mode == MODE_GROUP) ? ST_DIV : ST_CALC;
                end
            end
            ST_DIV: begin
                n_rem  = rem_ge ? PSIZE_W'(rem_shift - {1'b0, r_div}) : rem_shift[PSIZE_W-1:0];
                n_quot = {r_quot[QUEUED_W-2:0], rem_ge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (out_free) begin
                    n_out.whole_packets = '0;
                    case (r_mode)
                        MODE_GROUP: begin
                            n_credit = RATE_W'(credit_sum[FRACTION_BITS-1:0]);
                            if (desired_sum <= rate_whole) begin
                                n_inc_guard = r_sent + SEQUENCE_BITS'(whole_sat)
                                            + SEQUENCE_BITS'(1);
                            end
                            if (whole_sat == WHOLE_W'(1)) begin
                                n_dec_guard = r_sent + SEQUENCE_BITS'(2);
                            end
                            n_out.whole_packets = whole_sat;
                        end
                        MODE_ACK: begin
                            if (r_pnum >= r_inc_guard) begin
                                if (r_rate >= r_thresh) begin
                                    n_inc_guard = r_sent + SEQUENCE_BITS'(1);
                                end
                                n_rate = rate_inc[RATE_W] ? {RATE_W{1'b1}}
                                                          : rate_inc[RATE_W-1:0];
                            end
                        end
                        MODE_LOSS: begin
                            if (r_pnum >= r_dec_guard) begin
                                n_rate      = rate_half;
                                n_thresh    = rate_half;
                                n_dec_guard = r_sent + SEQUENCE_BITS'(1);
                            end
                        end
                        default: begin
                            n_sent = r_sent + SEQUENCE_BITS'(1);
                        end
                    endcase
                    n_out.packets_per_group = n_rate;
                    n_out.slow_start_limit  = n_thresh;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_psize     <= PACKET_SIZE_RESET;
            r_rate      <= ONE_FIXED;
            r_credit    <= '0;
            r_thresh    <= THRESHOLD_RESET;
            r_inc_guard <= '0;
            r_dec_guard <= '0;
            r_sent      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_rate      <= n_rate;
            r_credit    <= n_credit;
            r_thresh    <= n_thresh;
            r_inc_guard <= n_inc_guard;
            r_dec_guard <= n_dec_guard;
            r_sent      <= n_sent;
            if (i_cfg_valid) begin
                r_psize <= i_cfg_data;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_desired <= n_desired;
        r_pnum    <= n_pnum;
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_out     <= n_out;
    end

endmodule

FILE: sim/packet_rate_congestion_control_tb.sv
// ============================================================================
// packet_rate_congestion_control_tb
// Self-checking testbench for the packet rate congestion controller.
// ============================================================================
// A scoreboard class keeps its own copy of the controller state: rate, send
// credit, threshold, both guards, sent count and packet size. It predicts one
// result for every accepted request and compares each delivered result with
// the oldest prediction, field by field.
// Stimulus runs in this order:
// - A directed sequence covering guard edges, the halving floor and field
//   extremes.
// - Several random phases with different packet sizes, mostly realistic
//   rounds (group, sent, acknowledge, loss) mixed with random noise.
// - A run of back-to-back acknowledges that raises the rate, followed by
//   large groups at a one-byte packet size.
// The sender works in random bursts. The receiver stalls on its own pattern
// and holds off once for a long stretch.
// ============================================================================
module packet_rate_congestion_control_tb
    import prcc_pkg::*;
();

    localparam int CLK_HALF      = 5;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 85;
    localparam int RAMP_ITEMS    = 40;
    localparam int RUN_LIMIT     = 20_000_000;

    // Reference state of the controller and the queue of predicted results.
    class rate_scoreboard;
        logic [PSIZE_W-1:0]       packet_size;
        logic [RATE_W-1:0]        rate;
        logic [RATE_W-1:0]        send_credit;
        logic [RATE_W-1:0]        threshold;
        logic [SEQUENCE_BITS-1:0] increase_guard;
        logic [SEQUENCE_BITS-1:0] decrease_guard;
        logic [SEQUENCE_BITS-1:0] sent_count;
        t_out_item                pending_results[$];
        int                       mismatches;
        int                       results_checked;
        int                       requests_noted;

        function new();
            packet_size     = PACKET_SIZE_RESET;
            rate            = ONE_FIXED;
            send_credit     = '0;
            threshold       = THRESHOLD_RESET;
            increase_guard  = '0;
            decrease_guard  = '0;
            sent_count      = '0;
            mismatches      = 0;
            results_checked = 0;
            requests_noted  = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void set_packet_size(logic [PSIZE_W-1:0] value);
            packet_size = value;
        endfunction

        // Apply one request to the state and queue the result it produces.
        function void note_request(t_in_item req);
            logic [63:0]              divisor;
            logic [63:0]              desired;
            logic [63:0]              sum;
            logic [63:0]              whole;
            logic [63:0]              half;
            logic [SEQUENCE_BITS-1:0] pnum;
            t_out_item                res;
            pnum  = req.packet_number[SEQUENCE_BITS-1:0];
            whole = '0;
            case (req.mode)
                MODE_GROUP: begin
                    divisor = (packet_size == '0) ? 64'd1 : 64'(packet_size);
                    desired = 64'(req.desired_packets) + 64'(req.bytes_queued) / divisor;
                    sum = 64'(send_credit) + 64'(rate);
                    whole = sum >> FRACTION_BITS;
                    send_credit = RATE_W'(sum & ((64'd1 << FRACTION_BITS) - 64'd1));
                    if (whole > desired) begin
                        whole = desired;
                    end
                    if (whole > 64'hFFFF) begin
                        whole = 64'hFFFF;
                    end
                    if ((desired << FRACTION_BITS) <= 64'(rate)) begin
                        increase_guard = sent_count + SEQUENCE_BITS'(whole + 64'd1);
                    end
                    if (whole == 64'd1) begin
                        decrease_guard = sent_count + SEQUENCE_BITS'(2);
                    end
                end
                MODE_ACK: begin
                    if (pnum >= increase_guard) begin
                        if (rate >= threshold) begin
                            increase_guard = sent_count + SEQUENCE_BITS'(1);
                        end
                        sum = 64'(rate) + 64'(ONE_FIXED);
                        rate = (sum > 64'hFFFF_FFFF) ? '1 : sum[RATE_W-1:0];
                    end
                end
                MODE_LOSS: begin
                    if (pnum >= decrease_guard) begin
                        half = 64'(rate) >> 1;
                        if (half < 64'(ONE_FIXED)) begin
                            half = 64'(ONE_FIXED);
                        end
                        rate = half[RATE_W-1:0];
                        threshold = rate;
                        decrease_guard = sent_count + SEQUENCE_BITS'(1);
                    end
                end
                default: begin
                    sent_count = sent_count + SEQUENCE_BITS'(1);
                end
            endcase
            res.whole_packets     = whole[WHOLE_W-1:0];
            res.packets_per_group = rate;
            res.slow_start_limit  = threshold;
            pending_results.push_back(res);
            requests_noted++;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        // Compare a delivered result with the oldest prediction.
        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got.whole_packets !== want.whole_packets) begin
                report_mismatch($sformatf("result %0d whole_packets %h, expected %h",
                    results_checked, got.whole_packets, want.whole_packets));
            end
            if (got.packets_per_group !== want.packets_per_group) begin
                report_mismatch($sformatf("result %0d packets_per_group %h, expected %h",
                    results_checked, got.packets_per_group, want.packets_per_group));
            end
            if (got.slow_start_limit !== want.slow_start_limit) begin
                report_mismatch($sformatf("result %0d slow_start_limit %h, expected %h",
                    results_checked, got.slow_start_limit, want.slow_start_limit));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [PSIZE_W-1:0] i_cfg_data = '0;

    rate_scoreboard sb = new();

    // Sender pacing and receiver control shared between processes.
    int burst_left = 0;
    bit no_gaps = 1'b0;
    bit rx_free = 1'b0;
    bit hold_start = 1'b0;
    int size_writes = 0;

    packet_rate_congestion_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Monitor: results are checked before a request from the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_in_data);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_packet_size(i_cfg_data);
            end
        end
    end

    // Receiver: changing stall styles, plus a long hold-off when asked.
    initial begin
        int hold_left;
        int rx_left;
        int rx_style;
        hold_left = 0;
        rx_left = 0;
        rx_style = 0;
        forever begin
            @(negedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (rx_free) begin
                i_out_ready <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_style = $urandom_range(0, 2);
                    rx_left = $urandom_range(10, 120);
                end
                rx_left--;
                case (rx_style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic t_in_item make_request(logic [1:0] mode, logic [15:0] desired,
                                              logic [31:0] queued, logic [31:0] pnum);
        t_in_item req;
        req.mode            = mode;
        req.desired_packets = desired;
        req.bytes_queued    = queued;
        req.packet_number   = pnum;
        return req;
    endfunction

    task automatic idle_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Present one request and hold it until the block takes it.
    task automatic send_request(t_in_item req);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Send in bursts of random length separated by random gaps.
    task automatic offer(t_in_item req);
        if (burst_left == 0) begin
            if (!no_gaps && $urandom_range(0, 3) != 0) begin
                idle_input($urandom_range(1, 10));
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_request(req);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        idle_input(1);
        burst_left = 0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_packet_size(logic [PSIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        size_writes++;
    endtask

    function automatic logic [15:0] pick_desired();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 4));
            2: return 16'($urandom_range(0, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_queued();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return $urandom_range(0, 4 * (32'(sb.packet_size) + 1));
            2: return $urandom_range(0, 100000);
            default: return $urandom;
        endcase
    endfunction

    // Packet numbers mostly land close to a guard or the sent count.
    function automatic logic [31:0] pick_packet_number(logic [31:0] anchor);
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return 32'd0;
            2: return '1;
            default: return anchor + 32'($urandom_range(0, 5)) - 32'd3;
        endcase
    endfunction

    // Random traffic: mostly well-formed rounds, the rest random noise.
    task automatic run_random(int count, int hold_at);
        int sent_items;
        int n;
        logic [31:0] anchor;
        sent_items = 0;
        while (sent_items < count) begin
            if (sent_items >= hold_at && hold_at >= 0) begin
                hold_start = 1'b1;
                hold_at = -1;
            end
            if ($urandom_range(0, 99) < 20) begin
                offer(make_request(2'($urandom), 16'($urandom), $urandom, $urandom));
                sent_items++;
            end else begin
                offer(make_request(MODE_GROUP, pick_desired(), pick_queued(),
                                   $urandom));
                sent_items++;
                n = $urandom_range(0, 4);
                repeat (n) begin
                    offer(make_request(MODE_SENT, 16'($urandom), $urandom, $urandom));
                    sent_items++;
                end
                n = $urandom_range(0, 3);
                repeat (n) begin
                    anchor = $urandom_range(0, 1) ? sb.sent_count : sb.increase_guard;
                    offer(make_request(MODE_ACK, 16'($urandom), $urandom,
                                       pick_packet_number(anchor)));
                    sent_items++;
                end
                if ($urandom_range(0, 99) < 15) begin
                    anchor = $urandom_range(0, 1) ? sb.sent_count : sb.decrease_guard;
                    offer(make_request(MODE_LOSS, 16'($urandom), $urandom,
                                       pick_packet_number(anchor)));
                    sent_items++;
                end
            end
        end
    endtask

    // Main sequence.
    initial begin
        t_in_item directed[$];
        logic [PSIZE_W-1:0] sizes[6];
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Guard edges, halving floor and field extremes at the reset packet size.
        directed.push_back(make_request(MODE_GROUP, 16'd0, 32'd0, 32'd0));
        directed.push_back(make_request(MODE_SENT, '1, '1, '1));
        directed.push_back(make_request(MODE_ACK, 16'd0, 32'd0, 32'd0));
        directed.push_back(make_request(MODE_ACK, 16'd0, 32'd0, 32'd1));
        directed.push_back(make_request(MODE_GROUP, 16'd1, 32'd0, 32'd0));
        directed.push_back(make_request(MODE_LOSS, 16'd0, 32'd0, 32'd0));
        directed.push_back(make_request(MODE_LOSS, 16'd0, 32'd0, '1));
        directed.push_back(make_request(MODE_LOSS, 16'd0, 32'd0, '1));
        directed.push_back(make_request(MODE_ACK, 16'd0, 32'd0, '1));
        directed.push_back(make_request(MODE_ACK, 16'd0, 32'd0, 32'd1));
        directed.push_back(make_request(MODE_ACK, 16'd0, 32'd0, 32'd2));
        directed.push_back(make_request(MODE_GROUP, '1, '1, 32'd0));
        directed.push_back(make_request(MODE_GROUP, 16'd0, 32'd2999, 32'd0));
        directed.push_back(make_request(MODE_GROUP, 16'd0, 32'd3000, 32'd0));
        directed.push_back(make_request(MODE_SENT, 16'd0, 32'd0, 32'd0));
        directed.push_back(make_request(MODE_GROUP, 16'h8000, 32'h8000_0000, 32'd0));
        directed.push_back(make_request(MODE_LOSS, 16'd0, 32'd0, '1));
        directed.push_back(make_request(MODE_ACK, 16'd0, 32'd0, '1));
        directed.push_back(make_request(MODE_LOSS, 16'd0, 32'd0, '1));
        directed.push_back(make_request(MODE_GROUP, 16'd3, 32'd0, '1));
        foreach (directed[i]) begin
            offer(directed[i]);
        end
        drain_results();

        // Random phases across packet sizes, zero and both extremes among them.
        sizes[0] = '0;
        sizes[1] = 16'd1;
        sizes[2] = '1;
        sizes[3] = 16'($urandom_range(2, 200));
        sizes[4] = 16'($urandom);
        sizes[5] = PACKET_SIZE_RESET;
        foreach (sizes[p]) begin
            write_packet_size(sizes[p]);
            run_random(PHASE_ITEMS, (p == 2) ? 10 : -1);
            drain_results();
        end

        // Raise the rate with back-to-back acknowledges past every guard.
        rx_free = 1'b1;
        no_gaps = 1'b1;
        repeat (RAMP_ITEMS) begin
            send_request(make_request(MODE_ACK, 16'd0, 32'd0, '1));
        end
        no_gaps = 1'b0;
        rx_free = 1'b0;
        drain_results();

        // Large groups at a one-byte packet size, then a halving from the raised rate.
        write_packet_size(16'd1);
        repeat (4) offer(make_request(MODE_GROUP, '1, '1, 32'd0));
        offer(make_request(MODE_LOSS, 16'd0, 32'd0, '1));
        offer(make_request(MODE_GROUP, '1, '1, 32'd0));
        run_random(20, -1);
        drain_results();

        $display("Run covered %0d requests and %0d checked results, %0d size writes,",
                 sb.requests_noted, sb.results_checked, size_writes);
        $display("including a long receiver hold-off and an acknowledge ramp.");
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #RUN_LIMIT;
        $display("Mismatches found");
        $finish;
    end

endmodule
